// ===== hw/rtl/shp_pkg.sv =====
// ============================================================================
// shp_pkg: shared types and constants of the 3x3 sharpen stream filter
// Pixel and line-store types, border flags, register indexes and sizes.
// ============================================================================
`default_nettype none

package shp_pkg;

    localparam int unsigned MAX_WIDTH  = 2048;
    localparam int unsigned MAX_HEIGHT = 2048;

    localparam int unsigned CHAN_W    = 8;
    localparam int unsigned DIM_W     = 12;
    localparam int unsigned CFG_IDX_W = 4;
    localparam int unsigned COL_W     = $clog2(MAX_WIDTH);
    localparam int unsigned ROW_W     = $clog2(MAX_HEIGHT);
    // item count runs up to width*height + width
    localparam int unsigned CNT_W     = $clog2(MAX_WIDTH * MAX_HEIGHT + MAX_WIDTH + 1);

    localparam logic [DIM_W-1:0] WIDTH_RST  = DIM_W'(640);
    localparam logic [DIM_W-1:0] HEIGHT_RST = DIM_W'(480);

    localparam logic KIND_PIXEL = 1'b0;
    localparam logic KIND_FLUSH = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FRAME_WIDTH  = CFG_IDX_W'(0),
        REG_FRAME_HEIGHT = CFG_IDX_W'(1)
    } cfg_reg_t;

    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
    } pixel_t;

    // one column of the two previous rows
    typedef struct packed {
        pixel_t upper;
        pixel_t lower;
    } line_entry_t;

    // which neighbors fall outside the frame
    typedef struct packed {
        logic top;
        logic bottom;
        logic left;
        logic right;
    } border_t;

    // zero reads as one, large values saturate to the bound
    function automatic logic [DIM_W-1:0] limit_size(input logic [DIM_W-1:0] v,
                                                    input int unsigned maxv);
        logic [DIM_W-1:0] res;
        begin
            res = v;
            if (v == '0)
            begin
                res = DIM_W'(1);
            end
            else if (32'(v) > maxv)
            begin
                res = DIM_W'(maxv);
            end
            return res;
        end
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/shp_ifs.sv =====
// ============================================================================
// shp_ifs: channel interfaces of the sharpen stream filter
// Pixel input, result output and configuration write channels.
// ============================================================================
`default_nettype none

interface shp_pix_in_if;
    logic                       valid;
    logic                       ready;
    logic                       kind;
    logic [shp_pkg::CHAN_W-1:0] blue_in;
    logic [shp_pkg::CHAN_W-1:0] green_in;
    logic [shp_pkg::CHAN_W-1:0] red_in;

    modport source (output valid, output kind, output blue_in, output green_in,
                    output red_in, input ready);
    modport sink (input valid, input kind, input blue_in, input green_in,
                  input red_in, output ready);
endinterface

interface shp_pix_out_if;
    logic                       valid;
    logic                       ready;
    logic [shp_pkg::CHAN_W-1:0] blue_out;
    logic [shp_pkg::CHAN_W-1:0] green_out;
    logic [shp_pkg::CHAN_W-1:0] red_out;
    logic                       frame_end;

    modport source (output valid, output blue_out, output green_out, output red_out,
                    output frame_end, input ready);
    modport sink (input valid, input blue_out, input green_out, input red_out,
                  input frame_end, output ready);
endinterface

interface shp_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [shp_pkg::CFG_IDX_W-1:0] index;
    logic [shp_pkg::DIM_W-1:0]     data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/sharpen_3x3_rgb_stream.sv =====
// ============================================================================
// sharpen_3x3_rgb_stream: 3x3 sharpen filter on a raster RGB pixel stream
// Line store, sliding window, per-channel kernel and output register.
// ============================================================================
// Takes one 24-bit pixel per transfer in raster order and returns the pixel
// filtered with the sharpen kernel (center 5, direct neighbors -1, corners
// 0), each channel clipped to 0..255; frame edges are replicated. The result
// of pixel p leaves once pixel p+width+1 of the same frame has come in, so
// after the width*height pixels of a frame the source sends width+1 flush
// transfers (kind = 1) to drain it; frame_end marks the last result. Flush
// transfers during the pixel phase are dropped; pixel transfers during the
// drain phase count as flush. Throughput is one transfer per clock while the
// output is not stalled: a single line-store port pair (one read at accept,
// one write as stage 1 advances, same-column bypass) carries the two previous
// rows. A width or height write restarts the frame; the input is not ready in
// the cycle after any configuration write while the frame size product is
// recomputed. The line store has no clearing pass: entries not yet written in
// a frame are never selected thanks to the edge replication.
// ============================================================================
`default_nettype none

module sharpen_3x3_rgb_stream (
    input  wire logic         clk,
    input  wire logic         rst_n,
    shp_pix_in_if.sink        pix_in,
    shp_pix_out_if.source     pix_out,
    shp_cfg_if.sink           cfg
);

    localparam int unsigned DIM_W = shp_pkg::DIM_W;
    localparam int unsigned COL_W = shp_pkg::COL_W;
    localparam int unsigned ROW_W = shp_pkg::ROW_W;
    localparam int unsigned CNT_W = shp_pkg::CNT_W;

    // ---------------------------------------------------------------- config
    logic [DIM_W-1:0]   width_reg;
    logic [DIM_W-1:0]   height_reg;
    logic [CNT_W-1:0]   total_reg;      // pixels per frame
    logic               cfg_pend_reg;   // input hold-off after a write
    logic               cfg_acc;
    logic               cfg_known;
    logic [2*DIM_W-1:0] area;
    logic [DIM_W-1:0]   width_m1_full;
    logic [DIM_W-1:0]   height_m1_full;
    logic [COL_W-1:0]   width_m1;
    logic [ROW_W-1:0]   height_m1;

    assign cfg.ready = 1'b1;
    assign cfg_acc   = cfg.valid && cfg.ready;
    assign cfg_known = (cfg.index == shp_pkg::REG_FRAME_WIDTH)
                    || (cfg.index == shp_pkg::REG_FRAME_HEIGHT);

    assign area           = width_reg * height_reg;
    assign width_m1_full  = width_reg - DIM_W'(1);
    assign height_m1_full = height_reg - DIM_W'(1);
    assign width_m1       = width_m1_full[COL_W-1:0];
    assign height_m1      = height_m1_full[ROW_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg    <= shp_pkg::WIDTH_RST;
            height_reg   <= shp_pkg::HEIGHT_RST;
            total_reg    <= CNT_W'(32'(shp_pkg::WIDTH_RST) * 32'(shp_pkg::HEIGHT_RST));
            cfg_pend_reg <= 1'b0;
        end
        else
        begin
            total_reg    <= area[CNT_W-1:0];
            cfg_pend_reg <= cfg_acc;
            if (cfg_acc && (cfg.index == shp_pkg::REG_FRAME_WIDTH))
            begin
                width_reg <= shp_pkg::limit_size(cfg.data, shp_pkg::MAX_WIDTH);
            end
            if (cfg_acc && (cfg.index == shp_pkg::REG_FRAME_HEIGHT))
            begin
                height_reg <= shp_pkg::limit_size(cfg.data, shp_pkg::MAX_HEIGHT);
            end
        end
    end

    // ------------------------------------------------------- input position
    logic [CNT_W-1:0] in_count_reg;    // items of this frame taken so far
    logic [CNT_W-1:0] in_count_next;
    logic [COL_W-1:0] in_col_reg;
    logic [COL_W-1:0] in_col_next;
    logic [COL_W-1:0] out_col_reg;
    logic [COL_W-1:0] out_col_next;
    logic [ROW_W-1:0] out_row_reg;
    logic [ROW_W-1:0] out_row_next;

    logic             in_acc;
    logic             pixel_phase;
    logic             drop;
    logic             take;
    logic             has_res;
    logic             frame_done;
    shp_pkg::border_t border;
    shp_pkg::pixel_t  in_pix;

    // stage 1 / window advance
    logic                 s1_valid_reg;
    logic                 s1_result_reg;
    shp_pkg::pixel_t      s1_pix_reg;
    logic [COL_W-1:0]     s1_col_reg;
    shp_pkg::border_t     s1_border_reg;
    logic                 s1_adv;

    logic                 out_valid_reg;
    shp_pkg::pixel_t      out_pix_reg;
    logic                 out_end_reg;

    assign s1_adv       = s1_valid_reg && (!out_valid_reg || pix_out.ready);
    assign pix_in.ready = !cfg_pend_reg && (!s1_valid_reg || s1_adv);
    assign in_acc       = pix_in.valid && pix_in.ready;

    assign pixel_phase  = in_count_reg < total_reg;
    assign drop         = pixel_phase && (pix_in.kind == shp_pkg::KIND_FLUSH);
    assign take         = in_acc && !drop;
    // result once width+1 items are in
    assign has_res      = in_count_reg > CNT_W'(width_reg);

    assign border.top    = (out_row_reg == '0);
    assign border.bottom = (out_row_reg == height_m1);
    assign border.left   = (out_col_reg == '0);
    assign border.right  = (out_col_reg == width_m1);
    assign frame_done    = take && has_res && border.bottom && border.right;

    // drain phase feeds zeros into the line store
    assign in_pix.red   = pixel_phase ? pix_in.red_in   : '0;
    assign in_pix.green = pixel_phase ? pix_in.green_in : '0;
    assign in_pix.blue  = pixel_phase ? pix_in.blue_in  : '0;

    always_comb
    begin
        in_count_next = in_count_reg;
        in_col_next   = in_col_reg;
        out_col_next  = out_col_reg;
        out_row_next  = out_row_reg;
        if ((cfg_acc && cfg_known) || frame_done)
        begin
            in_count_next = '0;
            in_col_next   = '0;
            out_col_next  = '0;
            out_row_next  = '0;
        end
        else if (take)
        begin
            in_count_next = in_count_reg + CNT_W'(1);
            in_col_next   = (in_col_reg == width_m1) ? '0 : in_col_reg + COL_W'(1);
            if (has_res)
            begin
                if (border.right)
                begin
                    out_col_next = '0;
                    out_row_next = out_row_reg + ROW_W'(1);
                end
                else
                begin
                    out_col_next = out_col_reg + COL_W'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_count_reg <= '0;
            in_col_reg   <= '0;
            out_col_reg  <= '0;
            out_row_reg  <= '0;
        end
        else
        begin
            in_count_reg <= in_count_next;
            in_col_reg   <= in_col_next;
            out_col_reg  <= out_col_next;
            out_row_reg  <= out_row_next;
        end
    end

    // -------------------------------------------------------------- stage 1
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s1_result_reg <= 1'b0;
        end
        else if (take)
        begin
            s1_valid_reg  <= 1'b1;
            s1_result_reg <= has_res;
        end
        else if (s1_adv)
        begin
            s1_valid_reg  <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            s1_pix_reg    <= in_pix;
            s1_col_reg    <= in_col_reg;
            s1_border_reg <= border;
        end
    end

    // ---------------------------------------------------------- line store
    shp_pkg::line_entry_t lb_rd;
    shp_pkg::line_entry_t lb_wr;

    // column moves up one row, new pixel becomes the lower row
    assign lb_wr.upper = lb_rd.lower;
    assign lb_wr.lower = s1_pix_reg;

    shp_line_buf u_line_buf (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (take),
        .rd_addr (in_col_reg),
        .wr_en   (s1_adv),
        .wr_addr (s1_col_reg),
        .wr_data (lb_wr),
        .rd_data (lb_rd)
    );

    // -------------------------------------------------------------- window
    // Only the taps the kernel still needs after the shift are kept:
    // middle-row pixel of the center column, and the whole right column.
    shp_pkg::pixel_t win_mid_reg;   // center column, middle row
    shp_pkg::pixel_t win_top_reg;   // right column, top row
    shp_pkg::pixel_t win_cen_reg;   // right column, middle row
    shp_pkg::pixel_t win_bot_reg;   // right column, bottom row

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_mid_reg <= '0;
            win_top_reg <= '0;
            win_cen_reg <= '0;
            win_bot_reg <= '0;
        end
        else if (s1_adv)
        begin
            win_mid_reg <= win_cen_reg;
            win_top_reg <= lb_rd.upper;
            win_cen_reg <= lb_rd.lower;
            win_bot_reg <= s1_pix_reg;
        end
    end

    // After the shift the center is the old right-column middle pixel; its
    // neighbors are the old right column (top, bottom), the old center
    // (left) and the middle pixel of the column that enters now (right).
    shp_pkg::pixel_t k_c;
    shp_pkg::pixel_t k_a;
    shp_pkg::pixel_t k_b;
    shp_pkg::pixel_t k_l;
    shp_pkg::pixel_t k_r;
    shp_pkg::pixel_t k_y;

    assign k_c = win_cen_reg;
    assign k_a = s1_border_reg.top    ? k_c : win_top_reg;
    assign k_b = s1_border_reg.bottom ? k_c : win_bot_reg;
    assign k_l = s1_border_reg.left   ? k_c : win_mid_reg;
    assign k_r = s1_border_reg.right  ? k_c : lb_rd.lower;

    shp_kernel u_kernel (
        .c (k_c),
        .a (k_a),
        .b (k_b),
        .l (k_l),
        .r (k_r),
        .y (k_y)
    );

    // ------------------------------------------------------ output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_adv && s1_result_reg)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (pix_out.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv && s1_result_reg)
        begin
            out_pix_reg <= k_y;
            out_end_reg <= s1_border_reg.bottom && s1_border_reg.right;
        end
    end

    assign pix_out.valid     = out_valid_reg;
    assign pix_out.red_out   = out_pix_reg.red;
    assign pix_out.green_out = out_pix_reg.green;
    assign pix_out.blue_out  = out_pix_reg.blue;
    assign pix_out.frame_end = out_end_reg;

    // ----------------------------------------------------------- assertions
    a_frame_restart: assert property (@(posedge clk) disable iff (!rst_n)
        frame_done |=> (in_count_reg == '0) && (out_col_reg == '0) && (out_row_reg == '0))
        else $error("counters not cleared after last result of frame");

    a_pos_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
        (in_col_reg <= width_m1) && (out_col_reg <= width_m1) && (out_row_reg <= height_m1))
        else $error("position counter outside frame");

    a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !s1_adv) |=> s1_valid_reg && $stable(s1_col_reg) && !$past(take))
        else $error("stage 1 lost or overwritten while stalled");

    a_cfg_holdoff: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_acc |=> !pix_in.ready)
        else $error("input taken before frame size settled");

endmodule

`default_nettype wire

// ===== hw/rtl/shp_line_buf.sv =====
// ============================================================================
// shp_line_buf: two-row line store
// One entry per column holding the two previous rows; registered read with
// bypass of a write to the same column in the same cycle.
// ============================================================================
`default_nettype none

module shp_line_buf (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       rd_en,
    input  wire logic [shp_pkg::COL_W-1:0]  rd_addr,
    input  wire logic                       wr_en,
    input  wire logic [shp_pkg::COL_W-1:0]  wr_addr,
    input  wire shp_pkg::line_entry_t       wr_data,
    output shp_pkg::line_entry_t            rd_data
);

    shp_pkg::line_entry_t mem [shp_pkg::MAX_WIDTH];
    shp_pkg::line_entry_t q_reg;
    shp_pkg::line_entry_t byp_data_reg;
    logic                 byp_reg;
    logic                 byp_next;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            q_reg        <= mem[rd_addr];
            byp_data_reg <= wr_data;
        end
    end

    assign byp_next = rd_en ? (wr_en && (wr_addr == rd_addr)) : byp_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byp_reg <= 1'b0;
        end
        else
        begin
            byp_reg <= byp_next;
        end
    end

    assign rd_data = byp_reg ? byp_data_reg : q_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/shp_kernel.sv =====
// ============================================================================
// shp_kernel: sharpen kernel on one pixel
// 5*center minus the four direct neighbors, clipped to 0..255 per channel.
// ============================================================================
`default_nettype none

module shp_kernel (
    input  wire shp_pkg::pixel_t c,
    input  wire shp_pkg::pixel_t a,
    input  wire shp_pkg::pixel_t b,
    input  wire shp_pkg::pixel_t l,
    input  wire shp_pkg::pixel_t r,
    output shp_pkg::pixel_t      y
);

    function automatic logic [shp_pkg::CHAN_W-1:0] sharpen_chan(
        input logic [shp_pkg::CHAN_W-1:0] cc,
        input logic [shp_pkg::CHAN_W-1:0] ca,
        input logic [shp_pkg::CHAN_W-1:0] cb,
        input logic [shp_pkg::CHAN_W-1:0] cl,
        input logic [shp_pkg::CHAN_W-1:0] cr);
        logic [shp_pkg::CHAN_W+3:0] pos;
        logic [shp_pkg::CHAN_W+3:0] neg;
        logic [shp_pkg::CHAN_W+3:0] diff;
        logic [shp_pkg::CHAN_W-1:0] res;
        begin
            pos  = {2'b00, cc, 2'b00} + {4'b0000, cc};
            neg  = {4'b0000, ca} + {4'b0000, cb} + {4'b0000, cl} + {4'b0000, cr};
            diff = pos - neg;
            if (neg > pos)
            begin
                res = '0;
            end
            else if (diff > (shp_pkg::CHAN_W + 4)'(255))
            begin
                res = '1;
            end
            else
            begin
                res = diff[shp_pkg::CHAN_W-1:0];
            end
            return res;
        end
    endfunction

    always_comb
    begin
        y.red   = sharpen_chan(c.red, a.red, b.red, l.red, r.red);
        y.green = sharpen_chan(c.green, a.green, b.green, l.green, r.green);
        y.blue  = sharpen_chan(c.blue, a.blue, b.blue, l.blue, r.blue);
    end

endmodule

`default_nettype wire
